// ----- hw/rtl/ebr_pkg.sv -----
package ebr_pkg;

  localparam int TICK_BITS        = 16;
  localparam int SENSOR_FRAC_BITS = 10;

  localparam int SENSOR_W   = 11;
  localparam int LEVEL_W    = 12;
  localparam int BRIGHT_W   = 8;
  localparam int DEADBAND_W = 12;
  localparam int RTICKS_W   = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FULL_SCALE = 1 << SENSOR_FRAC_BITS;

  localparam int MUL_A_W = (2 * TICK_BITS > 2 * RTICKS_W) ? 2 * TICK_BITS : 2 * RTICKS_W;
  localparam int MUL_B_W = (TICK_BITS > RTICKS_W) ? TICK_BITS : RTICKS_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = LEVEL_W + 2 * TICK_BITS;
  localparam int DEN_W   = 2 * RTICKS_W;
  localparam int QUOT_W  = LEVEL_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  localparam logic [BRIGHT_W-1:0]   RST_MIN_BRIGHT = 8'd20;
  localparam logic [BRIGHT_W-1:0]   RST_MAX_BRIGHT = 8'd255;
  localparam logic [DEADBAND_W-1:0] RST_DEADBAND   = 12'd80;
  localparam logic [RTICKS_W-1:0]   RST_RAMP_TICKS = 16'd1000;
  localparam logic [LEVEL_W-1:0]    RST_LEVEL      = 12'd2192;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_BRIGHT = 2'd0,
    CFG_MAX_BRIGHT = 2'd1,
    CFG_DEADBAND   = 2'd2,
    CFG_RAMP_TICKS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_stat_t;

endpackage

// ----- hw/rtl/eased_brightness_ramp_top.sv -----
// An item without a ramp step passes through ST_MAP_MUL and ST_MAP_FIN before its result
// is registered. An item whose tick advances a running ramp first makes three passes through the
// shared multiplier and runs the restoring divider (one quotient bit per cycle), then the
// final ramp, mapping and deadband states. The next item can be taken once the result is
// registered, so a new item is not taken before the last one is finished, and ST_MAP_FIN
// waits while an earlier result is held by out_stall. Reset (rst_n low, synchronous)
// restores the register defaults and the 2192 ramp level.
module eased_brightness_ramp_top
  import ebr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SENSOR_W-1:0]   in_sensor_level,
  input  logic                  in_tick,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BRIGHT_W-1:0]   out_brightness,
  output logic                  out_ramping,
  output logic                  out_ramp_done,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_MUL_EE   = 8'b0000_0010,
    ST_MUL_RR   = 8'b0000_0100,
    ST_MUL_NUM  = 8'b0000_1000,
    ST_DIV      = 8'b0001_0000,
    ST_FIN_RAMP = 8'b0010_0000,
    ST_MAP_MUL  = 8'b0100_0000,
    ST_MAP_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [BRIGHT_W-1:0]   min_r, max_r;
  logic [DEADBAND_W-1:0] deadband_r;
  logic [RTICKS_W-1:0]   rticks_r;

  logic [LEVEL_W-1:0]     target_r, target_nxt;
  logic [LEVEL_W-1:0]     start_r, start_nxt;
  logic [LEVEL_W-1:0]     current_r, current_nxt;
  logic [TICK_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                   active_r, active_nxt;
  logic                   done_r, done_nxt;
  logic [SENSOR_W-1:0]    level_r, level_nxt;
  logic [2*TICK_BITS-1:0] ee_r, ee_nxt;
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic [LEVEL_W-1:0]     mapq_r, mapq_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BRIGHT_W-1:0] out_bright_r, out_bright_nxt;
  logic                out_ramping_r, out_ramping_nxt;
  logic                out_done_r, out_done_nxt;

  logic [RTICKS_W-1:0]  r_eff;
  logic [TICK_BITS-1:0] e_inc;
  logic                 in_xfer, out_free;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic signed [LEVEL_W:0] diff;
  logic                    diff_neg;
  logic [LEVEL_W-1:0]      mag;

  logic                    div_start;
  logic [QUOT_W-1:0]       quot;
  div_stat_t               div_stat;
  logic [LEVEL_W:0]        qf;
  logic signed [LEVEL_W+1:0] ramp_lvl;
  logic [LEVEL_W-1:0]      ramp_clamped;

  logic signed [BRIGHT_W:0]  span;
  logic                      span_neg;
  logic [BRIGHT_W-1:0]       span_abs;
  logic [LEVEL_W-1:0]        span_mag;
  logic signed [LEVEL_W+1:0] mapped_s;
  logic [LEVEL_W-1:0]        mapped;
  logic signed [LEVEL_W:0]   delta_s;
  logic [LEVEL_W-1:0]        delta_abs;
  logic                      retarget;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= RST_MIN_BRIGHT;
      max_r      <= RST_MAX_BRIGHT;
      deadband_r <= RST_DEADBAND;
      rticks_r   <= RST_RAMP_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MIN_BRIGHT: min_r      <= cfg_wdata[BRIGHT_W-1:0];
        CFG_MAX_BRIGHT: max_r      <= cfg_wdata[BRIGHT_W-1:0];
        CFG_DEADBAND:   deadband_r <= cfg_wdata[DEADBAND_W-1:0];
        CFG_RAMP_TICKS: rticks_r   <= cfg_wdata[RTICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign r_eff    = (rticks_r == '0) ? RTICKS_W'(1) : rticks_r;
  assign e_inc    = elapsed_r + 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign diff     = $signed({1'b0, target_r}) - $signed({1'b0, start_r});
  assign diff_neg = diff[LEVEL_W];
  assign mag      = diff_neg ? LEVEL_W'(-diff) : LEVEL_W'(diff);

  assign span     = $signed({1'b0, max_r}) - $signed({1'b0, min_r});
  assign span_neg = span[BRIGHT_W];
  assign span_abs = span_neg ? BRIGHT_W'(-span) : BRIGHT_W'(span);
  assign span_mag = {span_abs, 4'b0000};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_EE: begin
        mul_a = MUL_A_W'(elapsed_r);
        mul_b = MUL_B_W'(elapsed_r);
      end
      ST_MUL_RR: begin
        mul_a = MUL_A_W'(r_eff);
        mul_b = MUL_B_W'(r_eff);
      end
      ST_MUL_NUM: begin
        mul_a = MUL_A_W'(ee_r);
        mul_b = MUL_B_W'(mag);
      end
      ST_MAP_MUL: begin
        mul_a = MUL_A_W'(span_mag);
        mul_b = MUL_B_W'(level_r);
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign div_start = (state_r == ST_MUL_NUM);

  ebr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NUM_W'(mul_p)),
    .den   (den_r),
    .quot  (quot),
    .stat  (div_stat)
  );

  // A falling ramp rounds its step up so the level is the floor of the exact value.
  assign qf       = {1'b0, quot} + (LEVEL_W+1)'(diff_neg && div_stat.rem_nz);
  assign ramp_lvl = diff_neg ? ($signed({2'b00, start_r}) - $signed({1'b0, qf}))
                             : ($signed({2'b00, start_r}) + $signed({1'b0, qf}));
  assign ramp_clamped = ramp_lvl[LEVEL_W+1] ? '0 :
                        ramp_lvl[LEVEL_W]   ? '1 : ramp_lvl[LEVEL_W-1:0];

  assign mapped_s = span_neg ? ($signed({2'b00, min_r, 4'b0000}) - $signed({2'b00, mapq_r}))
                             : ($signed({2'b00, min_r, 4'b0000}) + $signed({2'b00, mapq_r}));
  assign mapped   = mapped_s[LEVEL_W+1] ? '0 :
                    mapped_s[LEVEL_W]   ? '1 : mapped_s[LEVEL_W-1:0];
  assign delta_s   = $signed({1'b0, target_r}) - $signed({1'b0, mapped});
  assign delta_abs = delta_s[LEVEL_W] ? LEVEL_W'(-delta_s) : LEVEL_W'(delta_s);
  assign retarget  = (delta_abs >= deadband_r);

  always_comb begin
    state_nxt       = state_r;
    target_nxt      = target_r;
    start_nxt       = start_r;
    current_nxt     = current_r;
    elapsed_nxt     = elapsed_r;
    active_nxt      = active_r;
    done_nxt        = done_r;
    level_nxt       = level_r;
    ee_nxt          = ee_r;
    den_nxt         = den_r;
    mapq_nxt        = mapq_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_bright_nxt  = out_bright_r;
    out_ramping_nxt = out_ramping_r;
    out_done_nxt    = out_done_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          level_nxt = (32'(in_sensor_level) > 32'(FULL_SCALE)) ?
                      SENSOR_W'(FULL_SCALE) : in_sensor_level;
          done_nxt  = 1'b0;
          state_nxt = ST_MAP_MUL;
          if (in_tick && active_r) begin
            if (32'(e_inc) >= 32'(r_eff)) begin
              elapsed_nxt = TICK_BITS'(r_eff);
              current_nxt = target_r;
              active_nxt  = 1'b0;
              done_nxt    = 1'b1;
            end else begin
              elapsed_nxt = e_inc;
              state_nxt   = ST_MUL_EE;
            end
          end
        end
      end
      ST_MUL_EE: begin
        ee_nxt    = (2*TICK_BITS)'(mul_p);
        state_nxt = ST_MUL_RR;
      end
      ST_MUL_RR: begin
        den_nxt   = DEN_W'(mul_p);
        state_nxt = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN_RAMP;
        end
      end
      ST_FIN_RAMP: begin
        current_nxt = ramp_clamped;
        state_nxt   = ST_MAP_MUL;
      end
      ST_MAP_MUL: begin
        mapq_nxt  = LEVEL_W'(mul_p >> SENSOR_FRAC_BITS);
        state_nxt = ST_MAP_FIN;
      end
      ST_MAP_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_bright_nxt  = current_r[LEVEL_W-1 -: BRIGHT_W];
          out_ramping_nxt = active_r || retarget;
          out_done_nxt    = done_r;
          if (retarget) begin
            target_nxt  = mapped;
            start_nxt   = {current_r[LEVEL_W-1:4], 4'b0000};
            elapsed_nxt = '0;
            active_nxt  = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    level_r      <= level_nxt;
    ee_r         <= ee_nxt;
    den_r        <= den_nxt;
    mapq_r       <= mapq_nxt;
    out_bright_r <= out_bright_nxt;
    out_ramping_r <= out_ramping_nxt;
    out_done_r   <= out_done_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= RST_LEVEL;
      start_r     <= RST_LEVEL;
      current_r   <= RST_LEVEL;
      elapsed_r   <= '0;
      active_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      start_r     <= start_nxt;
      current_r   <= current_nxt;
      elapsed_r   <= elapsed_nxt;
      active_r    <= active_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_brightness = out_bright_r;
  assign out_ramping    = out_ramping_r;
  assign out_ramp_done  = out_done_r;

  // An idle ramp always rests on its target.
  a_idle_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (current_r == target_r))
    else $error("idle ramp level differs from target");

  // The ramp step never overshoots the distance to the target.
  a_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN_RAMP) |-> (quot <= mag))
    else $error("ramp quotient exceeds target distance");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAP_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished item did not produce a result");

endmodule

// ----- hw/rtl/ebr_divider.sv -----
module ebr_divider
  import ebr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUOT_W-1:0] quot,
  output div_stat_t         stat
);

  logic [NUM_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     dsh_r, dsh_nxt;
  logic [QUOT_W-1:0]    quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 ge;

  // The quotient is known to fit in QUOT_W bits, so the divisor starts
  // shifted up by QUOT_W-1 places and moves down one place per cycle.
  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (QUOT_W - 1);
      quot_nxt = '0;
      cnt_nxt  = DIV_CNT_W'(QUOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot        = quot_r;
  assign stat.done   = done_r;
  assign stat.rem_nz = (rem_r != '0);

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ebr_pkg::*;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic                ramping;
    logic                ramp_done;
  } lamp_out_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    int unsigned value;
    int unsigned sensor;
    bit          tick;
    bit          typed;
    lamp_out_t   want;
  } lamp_row_t;

  localparam int DIR_ROWS = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SENSOR_W-1:0]   in_sensor_level;
  logic                  in_tick;
  logic                  out_valid;
  logic                  out_stall;
  logic [BRIGHT_W-1:0]   out_brightness;
  logic                  out_ramping;
  logic                  out_ramp_done;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lamp_out_t expected_lamp[$];
  int        errors;
  bit        calm;
  int        idle_odds;

  logic [BRIGHT_W-1:0]   m_min;
  logic [BRIGHT_W-1:0]   m_max;
  logic [DEADBAND_W-1:0] m_deadband;
  logic [RTICKS_W-1:0]   m_ticks;
  logic [LEVEL_W-1:0]    m_target;
  logic [LEVEL_W-1:0]    m_start;
  logic [LEVEL_W-1:0]    m_level;
  logic [TICK_BITS-1:0]  m_elapsed;
  logic                  m_active;

  lamp_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 0, 1'b0, 1'b1, '{8'd137, 1'b1, 1'b0}},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 0, 1'b1, 1'b0, '0},
    '{ROW_CFG, CFG_RAMP_TICKS, 0, 0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 0, 1'b1, 1'b1, '{8'd20, 1'b0, 1'b1}},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1024, 1'b1, 1'b1, '{8'd20, 1'b1, 1'b0}},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 2047, 1'b1, 1'b1, '{8'd255, 1'b0, 1'b1}},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1024, 1'b0, 1'b1, '{8'd255, 1'b0, 1'b0}},
    '{ROW_CFG, CFG_MIN_BRIGHT, 255, 0, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_MAX_BRIGHT, 0, 0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1024, 1'b0, 1'b1, '{8'd255, 1'b1, 1'b0}},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 512, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_DEADBAND, 4095, 0, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_RAMP_TICKS, 65535, 0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 0, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0}},
    '{ROW_CFG, CFG_DEADBAND, 0, 0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 512, 1'b1, 1'b0, '0},
    '{ROW_CFG, CFG_MIN_BRIGHT, 0, 0, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_MAX_BRIGHT, 255, 0, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_DEADBAND, 16, 0, 1'b0, 1'b0, '0},
    '{ROW_CFG, CFG_RAMP_TICKS, 3, 0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1024, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1024, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1024, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1023, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 1025, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 700, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 700, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 700, 1'b1, 1'b0, '0},
    '{ROW_ITEM, CFG_MIN_BRIGHT, 0, 0, 1'b1, 1'b0, '0}
  };

  eased_brightness_ramp_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sensor_level (in_sensor_level),
    .in_tick         (in_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_brightness  (out_brightness),
    .out_ramping     (out_ramping),
    .out_ramp_done   (out_ramp_done),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint clamp_level(longint v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Quadratic ease-in: start + (target - start) * e^2 / r^2, rounded toward minus infinity.
  function automatic logic [LEVEL_W-1:0] eased_level(longint e, longint r);
    longint diff;
    longint mag;
    longint num;
    longint den;
    longint q;
    bit     neg;
    diff = longint'(m_target) - longint'(m_start);
    neg  = diff < 0;
    mag  = neg ? -diff : diff;
    num  = mag * e * e;
    den  = r * r;
    q    = num / den;
    if (neg && (num % den) != 0) q = q + 1;
    return LEVEL_W'(clamp_level(longint'(m_start) + (neg ? -q : q)));
  endfunction

  task automatic step_lamp(input logic [SENSOR_W-1:0] sensor, input logic tick,
                           output lamp_out_t res);
    longint r;
    longint lv;
    longint span;
    longint mapped;
    longint delta;
    bit     done;
    done = 1'b0;
    r = (m_ticks == 0) ? 1 : longint'(m_ticks);
    if (tick && m_active) begin
      m_elapsed = m_elapsed + 1'b1;
      if (longint'(m_elapsed) >= r) begin
        m_elapsed = TICK_BITS'(r);
        m_level   = m_target;
        m_active  = 1'b0;
        done      = 1'b1;
      end else begin
        m_level = eased_level(longint'(m_elapsed), r);
      end
    end
    lv = (sensor > FULL_SCALE) ? FULL_SCALE : longint'(sensor);
    span = (longint'(m_max) - longint'(m_min)) * 16;
    mapped = clamp_level(longint'(m_min) * 16 + (span * lv) / FULL_SCALE);
    delta = longint'(m_target) - mapped;
    if (delta < 0) delta = -delta;
    if (delta >= longint'(m_deadband)) begin
      m_target  = LEVEL_W'(mapped);
      m_start   = m_level & 12'hFF0;
      m_elapsed = '0;
      m_active  = 1'b1;
    end
    res.brightness = m_level[LEVEL_W-1:4];
    res.ramping    = m_active;
    res.ramp_done  = done;
  endtask

  task automatic transfer_reading(input logic [SENSOR_W-1:0] sensor, input logic tick,
                                  input bit typed, input lamp_out_t want);
    lamp_out_t got;
    in_valid        <= 1'b1;
    in_sensor_level <= sensor;
    in_tick         <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_lamp(sensor, tick, got);
    expected_lamp.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!calm && idle_odds > 0 && $urandom_range(0, 9) < idle_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_lamp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MIN_BRIGHT: m_min = value[BRIGHT_W-1:0];
      CFG_MAX_BRIGHT: m_max = value[BRIGHT_W-1:0];
      CFG_DEADBAND:   m_deadband = value[DEADBAND_W-1:0];
      CFG_RAMP_TICKS: m_ticks = value[RTICKS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [BRIGHT_W-1:0] pick_brightness();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return BRIGHT_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DEADBAND_W-1:0] pick_deadband();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DEADBAND_W'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [RTICKS_W-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return RTICKS_W'($urandom_range(13, 400));
      default: return RTICKS_W'($urandom_range(1, 12));
    endcase
  endfunction

  always @(posedge clk) begin
    lamp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lamp.size() == 0) begin
        $error("unexpected result transfer: brightness %0d ramping %0b ramp_done %0b",
               out_brightness, out_ramping, out_ramp_done);
        errors++;
      end else begin
        want = expected_lamp.pop_front();
        if (out_brightness !== want.brightness) begin
          $error("brightness: expected %0d, actual %0d", want.brightness, out_brightness);
          errors++;
        end
        if (out_ramping !== want.ramping) begin
          $error("ramping: expected %0b, actual %0b", want.ramping, out_ramping);
          errors++;
        end
        if (out_ramp_done !== want.ramp_done) begin
          $error("ramp_done: expected %0b, actual %0b", want.ramp_done, out_ramp_done);
          errors++;
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned         hold;
    int unsigned         roll;
    logic [SENSOR_W-1:0] sensor;
    in_valid        = 1'b0;
    in_sensor_level = '0;
    in_tick         = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_MIN_BRIGHT;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    errors          = 0;
    calm            = 1'b0;
    idle_odds       = 3;
    hold            = 0;
    m_min      = RST_MIN_BRIGHT;
    m_max      = RST_MAX_BRIGHT;
    m_deadband = RST_DEADBAND;
    m_ticks    = RST_RAMP_TICKS;
    m_target   = RST_LEVEL;
    m_start    = RST_LEVEL;
    m_level    = RST_LEVEL;
    m_elapsed  = '0;
    m_active   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, CFG_DATA_W'(dir_rows[i].value));
      end else begin
        sender_gap();
        transfer_reading(SENSOR_W'(dir_rows[i].sensor), dir_rows[i].tick,
                         dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Each phase sets new register values, then sends readings near a held level,
    // with occasional jumps of that level and out-of-range noise.
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(CFG_MIN_BRIGHT, {8'($urandom), pick_brightness()});
      write_reg(CFG_MAX_BRIGHT, {8'($urandom), pick_brightness()});
      write_reg(CFG_DEADBAND, {4'($urandom), pick_deadband()});
      write_reg(CFG_RAMP_TICKS, pick_ticks());
      idle_odds = (ph % 3 == 0) ? 0 : 4;
      for (int k = 0; k < 100; k++) begin
        if (ph == 12 && k >= 40) calm = 1'b1;
        roll = $urandom_range(0, 9);
        if (roll < 2) hold = $urandom_range(0, FULL_SCALE);
        if (roll == 9) sensor = SENSOR_W'($urandom_range(0, 2047));
        else sensor = SENSOR_W'(hold + $urandom_range(0, 8));
        sender_gap();
        transfer_reading(sensor, $urandom_range(0, 4) != 0, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- eased_brightness_ramp_top.f -----
hw/rtl/ebr_pkg.sv
hw/rtl/ebr_divider.sv
hw/rtl/eased_brightness_ramp_top.sv
tb/sv/testbench.sv
